>>> hdl/pcpm_pkg.sv
// Shared types and constants for the periodic close-point merger.
// No dependencies; used by every module of the block.
package pcpm_pkg;

    localparam int NAXES     = 3;
    localparam int COORD_W   = 32;
    localparam int BOX_W     = 31;
    localparam int SQ_W      = 2 * BOX_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [BOX_W-1:0] RADIUS_RST = 31'd196608;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

    typedef logic [NAXES-1:0][COORD_W-1:0] t_coord;
    typedef logic [NAXES-1:0][BOX_W-1:0]   t_box;

    typedef struct packed {
        logic   merge;
        t_coord mid;
    } t_pair_res;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ROW_RD,
        S_ROW_CAP,
        S_RUN,
        S_OUT
    } t_state;

endpackage

>>> hdl/pcpm_cfg_regs.sv
// Configuration registers: box lengths and merge radius, plus the squared radius.
// Depends on pcpm_pkg.
module pcpm_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcpm_pkg::BOX_W-1:0]         i_cfg_data,
    output pcpm_pkg::t_box                     o_box,
    output logic [pcpm_pkg::SQ_W-1:0]          o_r2
);

    pcpm_pkg::t_box                 r_box;
    logic [pcpm_pkg::BOX_W-1:0]     r_radius;
    logic [pcpm_pkg::SQ_W-1:0]      r_r2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box    <= '0;
            r_radius <= pcpm_pkg::RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcpm_pkg::CFG_BOX_X:  r_box[0] <= i_cfg_data;
                pcpm_pkg::CFG_BOX_Y:  r_box[1] <= i_cfg_data;
                pcpm_pkg::CFG_BOX_Z:  r_box[2] <= i_cfg_data;
                pcpm_pkg::CFG_RADIUS: r_radius <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    assign o_box = r_box;
    assign o_r2  = r_r2;

endmodule

>>> hdl/pcpm_pair_unit.sv
// Pipelined pair test: minimum-image difference, squared distance, compare, midpoint.
// Depends on pcpm_pkg. A merge result flushes the younger pairs in flight.
module pcpm_pair_unit #(
    parameter int IDX_W = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [IDX_W-1:0]              i_j,
    input  pcpm_pkg::t_coord              i_pi,
    input  pcpm_pkg::t_coord              i_pj,
    input  pcpm_pkg::t_box                i_box,
    input  logic [pcpm_pkg::SQ_W-1:0]     i_r2,
    output pcpm_pkg::t_pair_res           o_res,
    output logic [IDX_W-1:0]              o_res_j,
    output logic                          o_busy
);

    localparam logic signed [34:0] LIM_POS = 35'sd2147483647;
    localparam logic signed [34:0] LIM_NEG = -35'sd2147483647;

    logic [5:1]                    r_v;
    logic [IDX_W-1:0]              r_j1, r_j2, r_j3, r_j4, r_j5;
    pcpm_pkg::t_coord              r_pj1, r_pj2, r_pj3, r_pj4;
    logic signed [32:0]            r_d1 [pcpm_pkg::NAXES];
    logic signed [34:0]            r_d2 [pcpm_pkg::NAXES];
    logic signed [34:0]            r_d3 [pcpm_pkg::NAXES];
    logic [pcpm_pkg::BOX_W-1:0]    r_mag4 [pcpm_pkg::NAXES];
    pcpm_pkg::t_coord              r_d4;
    logic                          r_far4, r_far5;
    logic [pcpm_pkg::SQ_W-1:0]     r_sq5 [pcpm_pkg::NAXES];
    pcpm_pkg::t_coord              r_mid5;

    logic signed [32:0]            n_d1 [pcpm_pkg::NAXES];
    logic signed [34:0]            n_d2 [pcpm_pkg::NAXES];
    logic signed [34:0]            n_d3 [pcpm_pkg::NAXES];
    logic [pcpm_pkg::BOX_W-1:0]    n_mag4 [pcpm_pkg::NAXES];
    logic                          n_far4;
    pcpm_pkg::t_coord              n_mid5;
    logic [pcpm_pkg::SUM_W-1:0]    sum;
    logic                          merge;

    always_comb begin
        logic signed [34:0] b;
        logic signed [34:0] dd;
        logic signed [32:0] h;
        logic signed [32:0] s;
        n_far4 = 1'b0;
        for (int a = 0; a < pcpm_pkg::NAXES; a++) begin
            b = $signed({4'b0000, i_box[a]});
            n_d1[a] = $signed({i_pi[a][31], i_pi[a]}) - $signed({i_pj[a][31], i_pj[a]});
            dd = $signed({{2{r_d1[a][32]}}, r_d1[a]});
            n_d2[a] = ((dd <<< 1) > b) ? (dd - b) : dd;
            n_d3[a] = ((r_d2[a] <<< 1) < -b) ? (r_d2[a] + b) : r_d2[a];
            if ((r_d3[a] > LIM_POS) || (r_d3[a] < LIM_NEG)) begin
                n_far4 = 1'b1;
            end
            n_mag4[a] = r_d3[a][34] ? 31'(-r_d3[a]) : r_d3[a][30:0];
            h = $signed({r_d4[a][31], r_d4[a]}) >>> 1;
            s = h + $signed({r_pj4[a][31], r_pj4[a]});
            if (s[32] != s[31]) begin
                n_mid5[a] = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                n_mid5[a] = s[31:0];
            end
        end
    end

    assign sum   = pcpm_pkg::SUM_W'(r_sq5[0]) + pcpm_pkg::SUM_W'(r_sq5[1])
                 + pcpm_pkg::SUM_W'(r_sq5[2]);
    assign merge = r_v[5] && !r_far5 && (sum < pcpm_pkg::SUM_W'(i_r2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:1], i_valid} & {5{!merge}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_j1   <= i_j;
        r_j2   <= r_j1;
        r_j3   <= r_j2;
        r_j4   <= r_j3;
        r_j5   <= r_j4;
        r_pj1  <= i_pj;
        r_pj2  <= r_pj1;
        r_pj3  <= r_pj2;
        r_pj4  <= r_pj3;
        r_far4 <= n_far4;
        r_far5 <= r_far4;
        r_mid5 <= n_mid5;
        for (int a = 0; a < pcpm_pkg::NAXES; a++) begin
            r_d1[a]   <= n_d1[a];
            r_d2[a]   <= n_d2[a];
            r_d3[a]   <= n_d3[a];
            r_mag4[a] <= n_mag4[a];
            r_d4[a]   <= r_d3[a][31:0];
            r_sq5[a]  <= r_mag4[a] * r_mag4[a];
        end
    end

    assign o_res.merge = merge;
    assign o_res.mid   = r_mid5;
    assign o_res_j     = r_j5;
    assign o_busy      = |r_v;

endmodule

>>> hdl/periodic_close_point_merger_top.sv
// Periodic close-point merger, top level: atom memories, pass sequencer, result stream.
// Depends on pcpm_pkg, pcpm_cfg_regs and pcpm_pair_unit.
//
// Usage: atoms are offered on i_pos_x/y/z with start; a transaction completes when
// start is high and busy is low. Atoms load at one per cycle. The atom with
// i_final_atom set closes the set; busy then rises for the merge pass and result
// stream. Atoms beyond MAX_ATOMS are dropped and o_overflowed is set on every result.
// Pass: per atom i, the atom is fetched (S_ROW_RD and S_ROW_CAP), each later atom j
// is issued into the pair pipeline at one per cycle while no merge occurs, the pipeline
// drains, and atom i is written back; each merge flushes the pipeline and reissues from
// the atom after the merged one. The pass is bound by the single coordinate read port.
// Results: one per loaded atom, one per cycle, each on the o_ ports for exactly one
// cycle marked by o_strobe; o_end_of_set marks the last. The receiver cannot stall.
// busy falls in the cycle of the last result; a new set may load at once.
// Config: i_cfg_* writes a register whenever valid (ready is always high); write
// only while busy is low. Reset (i_rst_n low, synchronous) empties the set and
// restores register defaults; no memory clearing pass is needed.
module periodic_close_point_merger_top #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [pcpm_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [pcpm_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [pcpm_pkg::COORD_W-1:0]  i_pos_z,
    input  logic                                 i_final_atom,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcpm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pcpm_pkg::BOX_W-1:0]           i_cfg_data,
    output logic                                 o_strobe,
    output logic [pcpm_pkg::OUT_IDX_W-1:0]       o_atom_index,
    output logic signed [pcpm_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [pcpm_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [pcpm_pkg::COORD_W-1:0]  o_out_z,
    output logic                                 o_removed,
    output logic                                 o_overflowed,
    output logic                                 o_end_of_set
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ATOMS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    pcpm_pkg::t_box               box;
    logic [pcpm_pkg::SQ_W-1:0]    r2;
    pcpm_pkg::t_pair_res          res;
    logic [AW-1:0]                res_j;
    logic                         pair_busy;

    pcpm_pkg::t_state             r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic [CW-1:0]                r_i, n_i;
    logic [CW-1:0]                r_jn, n_jn;
    logic [CW-1:0]                r_k, n_k;
    logic                         r_s0_v, n_s0_v;
    logic [AW-1:0]                r_s0_j, n_s0_j;
    pcpm_pkg::t_coord             r_pi, n_pi;
    logic                         r_ov, n_ov;
    logic [pcpm_pkg::OUT_IDX_W-1:0] r_oidx, n_oidx;
    logic                         r_oend, n_oend;
    logic                         r_oovf, n_oovf;

    pcpm_pkg::t_coord             r_cmem [MAX_ATOMS];
    logic                         r_fmem [MAX_ATOMS];
    pcpm_pkg::t_coord             r_crd;
    logic                         r_frd;

    logic                         c_we, c_re, f_we, f_wdata, f_re;
    logic [AW-1:0]                c_waddr, c_raddr, f_waddr;
    pcpm_pkg::t_coord             c_wdata;

    pcpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_box       (box),
        .o_r2        (r2)
    );

    pcpm_pair_unit #(
        .IDX_W (AW)
    ) u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_v),
        .i_j     (r_s0_j),
        .i_pi    (r_pi),
        .i_pj    (r_crd),
        .i_box   (box),
        .i_r2    (r2),
        .o_res   (res),
        .o_res_j (res_j),
        .o_busy  (pair_busy)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_jn    = r_jn;
        n_k     = r_k;
        n_s0_v  = 1'b0;
        n_s0_j  = r_s0_j;
        n_pi    = r_pi;
        n_ov    = 1'b0;
        n_oidx  = r_oidx;
        n_oend  = r_oend;
        n_oovf  = r_oovf;
        c_we    = 1'b0;
        c_waddr = r_count[AW-1:0];
        c_wdata = {i_pos_z, i_pos_y, i_pos_x};
        c_re    = 1'b0;
        c_raddr = r_i[AW-1:0];
        f_we    = 1'b0;
        f_waddr = r_count[AW-1:0];
        f_wdata = 1'b0;
        f_re    = 1'b0;
        busy    = 1'b1;

        unique case (r_state)
            pcpm_pkg::S_LOAD: begin
                busy = 1'b0;
                if (start) begin
                    if (r_count != CNT_MAX) begin
                        c_we    = 1'b1;
                        f_we    = 1'b1;
                        n_count = r_count + ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_atom) begin
                        n_i     = '0;
                        n_state = pcpm_pkg::S_ROW_RD;
                    end
                end
            end
            pcpm_pkg::S_ROW_RD: begin
                c_re    = 1'b1;
                c_raddr = r_i[AW-1:0];
                n_jn    = r_i + ONE;
                n_state = pcpm_pkg::S_ROW_CAP;
            end
            pcpm_pkg::S_ROW_CAP: begin
                n_pi    = r_crd;
                n_state = pcpm_pkg::S_RUN;
            end
            pcpm_pkg::S_RUN: begin
                priority if (res.merge) begin
                    n_pi    = res.mid;
                    f_we    = 1'b1;
                    f_waddr = res_j;
                    f_wdata = 1'b1;
                    n_jn    = CW'(res_j) + ONE;
                end else if (r_jn != r_count) begin
                    c_re    = 1'b1;
                    c_raddr = r_jn[AW-1:0];
                    n_s0_v  = 1'b1;
                    n_s0_j  = r_jn[AW-1:0];
                    n_jn    = r_jn + ONE;
                end else if (!r_s0_v && !pair_busy) begin
                    c_we    = 1'b1;
                    c_waddr = r_i[AW-1:0];
                    c_wdata = r_pi;
                    if (r_i + ONE == r_count) begin
                        n_k     = '0;
                        n_state = pcpm_pkg::S_OUT;
                    end else begin
                        n_i     = r_i + ONE;
                        n_state = pcpm_pkg::S_ROW_RD;
                    end
                end else begin
                    n_s0_v = 1'b0;
                end
            end
            pcpm_pkg::S_OUT: begin
                c_re    = 1'b1;
                f_re    = 1'b1;
                c_raddr = r_k[AW-1:0];
                n_ov    = 1'b1;
                n_oidx  = pcpm_pkg::OUT_IDX_W'(r_k);
                n_oend  = (r_k + ONE == r_count);
                n_oovf  = r_ovf;
                if (r_k + ONE == r_count) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = pcpm_pkg::S_LOAD;
                end else begin
                    n_k = r_k + ONE;
                end
            end
            default: n_state = pcpm_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcpm_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_jn    <= '0;
            r_k     <= '0;
            r_s0_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_jn    <= n_jn;
            r_k     <= n_k;
            r_s0_v  <= n_s0_v;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_j <= n_s0_j;
        r_pi   <= n_pi;
        r_oidx <= n_oidx;
        r_oend <= n_oend;
        r_oovf <= n_oovf;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_crd <= r_cmem[c_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fmem[f_waddr] <= f_wdata;
        end
        if (f_re) begin
            r_frd <= r_fmem[c_raddr];
        end
    end

    assign o_strobe     = r_ov;
    assign o_atom_index = r_oidx;
    assign o_out_x      = $signed(r_crd[0]);
    assign o_out_y      = $signed(r_crd[1]);
    assign o_out_z      = $signed(r_crd[2]);
    assign o_removed    = r_frd;
    assign o_overflowed = r_oovf;
    assign o_end_of_set = r_oend;

endmodule

>>> tb/tb_top.sv
// Testbench for periodic_close_point_merger_top: directed rows, then random atom sets.
// Results are checked against a behavioral merge-pass predictor kept in this file.
// Depends on pcpm_pkg and periodic_close_point_merger_top.
module tb_top;
    import pcpm_pkg::*;

    localparam int MAX_ATOMS  = 64;
    localparam int RAND_ITEMS = 110;
    localparam int SPAN       = 32'h30000;
    localparam logic [BOX_W-1:0] REG_MAX = '1;
    localparam longint FAR_LIM = 64'sd2147483648;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [OUT_IDX_W-1:0] idx;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic                 removed;
        logic                 ovf;
        logic                 eos;
    } atom_out_t;

    typedef enum logic {ROW_ATOM, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic                 closes;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [BOX_W-1:0]     reg_val;
        bit                   typed;
        logic [COORD_W-1:0]   ex;
        logic [COORD_W-1:0]   ey;
        logic [COORD_W-1:0]   ez;
    } stim_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] i_pos_x = '0;
    logic signed [COORD_W-1:0] i_pos_y = '0;
    logic signed [COORD_W-1:0] i_pos_z = '0;
    logic                      i_final_atom = 1'b0;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = '0;
    logic [BOX_W-1:0]          i_cfg_data   = '0;
    logic                      o_strobe;
    logic [OUT_IDX_W-1:0]      o_atom_index;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;
    logic                      o_removed;
    logic                      o_overflowed;
    logic                      o_end_of_set;

    // predictor state
    logic [BOX_W-1:0]          box_len [NAXES];
    logic [BOX_W-1:0]          radius;
    logic signed [COORD_W-1:0] atom_pos [MAX_ATOMS][NAXES];
    bit                        atom_gone [MAX_ATOMS];
    int                        n_loaded;
    bit                        dropped_any;

    atom_out_t expected_atoms[$];
    stim_row_t stim_rows[$];
    int        n_mismatch = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    periodic_close_point_merger_top #(.MAX_ATOMS(MAX_ATOMS)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_final_atom (i_final_atom),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_atom_index (o_atom_index),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_removed    (o_removed),
        .o_overflowed (o_overflowed),
        .o_end_of_set (o_end_of_set)
    );

    function automatic longint fold_axis(longint d, logic [BOX_W-1:0] b);
        longint bl;
        bl = longint'({1'b0, b});
        if (2 * d > bl) d = d - bl;
        if (2 * d < -bl) d = d + bl;
        return d;
    endfunction

    function automatic logic [COORD_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[COORD_W-1:0];
    endfunction

    function automatic void merge_and_emit();
        u64_t      rad;
        u64_t      r2;
        u64_t      rr;
        longint    d [NAXES];
        bit        far;
        atom_out_t res;
        rad = radius;
        r2  = rad * rad;
        for (int k = 0; k < MAX_ATOMS; k++) atom_gone[k] = 1'b0;
        for (int i = 0; i < n_loaded; i++) begin
            for (int j = i + 1; j < n_loaded; j++) begin
                far = 1'b0;
                rr  = 0;
                for (int a = 0; a < NAXES; a++) begin
                    d[a] = fold_axis(longint'(atom_pos[i][a]) - longint'(atom_pos[j][a]),
                                     box_len[a]);
                    if (d[a] >= FAR_LIM || d[a] <= -FAR_LIM) far = 1'b1;
                end
                if (!far) begin
                    for (int a = 0; a < NAXES; a++) rr = rr + u64_t'(d[a] * d[a]);
                    if (rr < r2) begin
                        for (int a = 0; a < NAXES; a++)
                            atom_pos[i][a] = clamp32((d[a] >>> 1) + longint'(atom_pos[j][a]));
                        atom_gone[j] = 1'b1;
                    end
                end
            end
        end
        for (int k = 0; k < n_loaded; k++) begin
            res.idx     = k[OUT_IDX_W-1:0];
            res.x       = atom_pos[k][0];
            res.y       = atom_pos[k][1];
            res.z       = atom_pos[k][2];
            res.removed = atom_gone[k];
            res.ovf     = dropped_any;
            res.eos     = (k == n_loaded - 1);
            expected_atoms.push_back(res);
        end
        n_loaded    = 0;
        dropped_any = 1'b0;
    endfunction

    function automatic void load_atom(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic [COORD_W-1:0] z, logic closes);
        if (n_loaded < MAX_ATOMS) begin
            atom_pos[n_loaded][0] = x;
            atom_pos[n_loaded][1] = y;
            atom_pos[n_loaded][2] = z;
            n_loaded++;
        end else begin
            dropped_any = 1'b1;
        end
        if (closes) merge_and_emit();
    endfunction

    function automatic void add_atom(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [COORD_W-1:0] z, logic closes);
        stim_row_t r;
        r        = '{kind: ROW_ATOM, default: '0};
        r.kind   = ROW_ATOM;
        r.x      = x;
        r.y      = y;
        r.z      = z;
        r.closes = closes;
        stim_rows.push_back(r);
    endfunction

    // single-atom set: comes back unchanged, index 0, last of set
    function automatic void add_typed(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic [COORD_W-1:0] z, logic [COORD_W-1:0] ex,
                                      logic [COORD_W-1:0] ey, logic [COORD_W-1:0] ez);
        stim_row_t r;
        r        = '{kind: ROW_ATOM, default: '0};
        r.kind   = ROW_ATOM;
        r.x      = x;
        r.y      = y;
        r.z      = z;
        r.closes = 1'b1;
        r.typed  = 1'b1;
        r.ex     = ex;
        r.ey     = ey;
        r.ez     = ez;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
        stim_row_t r;
        r         = '{kind: ROW_REG, default: '0};
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        stim_rows.push_back(r);
    endfunction

    task automatic hold_start_low();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        hold_start_low();
        while (expected_atoms.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BOX_X:  box_len[0] = val;
            CFG_BOX_Y:  box_len[1] = val;
            CFG_BOX_Z:  box_len[2] = val;
            CFG_RADIUS: radius     = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_atom(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z, logic closes, bit gaps);
        if (gaps && $urandom_range(99) < 28) begin
            hold_start_low();
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_pos_z      <= z;
        i_final_atom <= closes;
        do @(posedge i_clk); while (busy);
        load_atom(x, y, z, closes);
    endtask

    function automatic logic [BOX_W-1:0] pick_reg(bit is_radius);
        case ($urandom_range(3))
            0: return '0;
            1: return REG_MAX;
            2: return BOX_W'($urandom);
            default: return is_radius ? BOX_W'($urandom_range(32'h8000, 32'h60000))
                                      : BOX_W'($urandom_range(32'h10000, 32'h200000));
        endcase
    endfunction

    // clustered sets (modes 1 to 3) make merges likely; there some atoms are shifted by a box length to wrap
    task automatic send_set(int size, bit gaps);
        int                 mode;
        int                 off;
        logic [COORD_W-1:0] base [NAXES];
        logic [COORD_W-1:0] c [NAXES];
        mode = $urandom_range(3);
        for (int a = 0; a < NAXES; a++) begin
            base[a] = $urandom;
            if ($urandom_range(3) == 0)
                base[a] = $urandom_range(1) ? 32'h7FFE0000 : 32'h80020000;
        end
        for (int k = 0; k < size; k++) begin
            for (int a = 0; a < NAXES; a++) begin
                if (mode == 0) begin
                    c[a] = $urandom;
                end else begin
                    off  = int'($urandom_range(0, 2 * SPAN)) - SPAN;
                    c[a] = base[a] + off;
                    if ($urandom_range(3) == 0) c[a] = c[a] + {1'b0, box_len[a]};
                end
            end
            send_atom(c[0], c[1], c[2], k == size - 1, gaps);
        end
    endtask

    always @(posedge i_clk) begin
        atom_out_t want;
        atom_out_t got;
        if (i_rst_n && o_strobe) begin
            got.idx     = o_atom_index;
            got.x       = o_out_x;
            got.y       = o_out_y;
            got.z       = o_out_z;
            got.removed = o_removed;
            got.ovf     = o_overflowed;
            got.eos     = o_end_of_set;
            if (expected_atoms.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("tb: unexpected result idx %0d x %h y %h z %h",
                             got.idx, got.x, got.y, got.z);
            end else begin
                want = expected_atoms.pop_front();
                if (got.idx !== want.idx || got.x !== want.x || got.y !== want.y ||
                    got.z !== want.z || got.removed !== want.removed ||
                    got.ovf !== want.ovf || got.eos !== want.eos) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("tb: mismatch exp idx %0d %h %h %h rm %b ov %b eos %b",
                                 want.idx, want.x, want.y, want.z, want.removed, want.ovf,
                                 want.eos, " got idx %0d %h %h %h rm %b ov %b eos %b",
                                 got.idx, got.x, got.y, got.z, got.removed, got.ovf,
                                 got.eos);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int        sent;
        int        phase;
        int        n_sets;
        int        waited;
        int        set_size;
        stim_row_t r;
        atom_out_t typed;
        box_len[0]  = '0;
        box_len[1]  = '0;
        box_len[2]  = '0;
        radius      = RADIUS_RST;
        n_loaded    = 0;
        dropped_any = 1'b0;

        add_typed(32'h7FFFFFFF, 32'h80000000, 32'h00000000,
                  32'h7FFFFFFF, 32'h80000000, 32'h00000000);
        add_typed(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                  32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        // removed atom still compared later
        add_atom(32'h0, 32'h0, 32'h0, 1'b0);
        add_atom(32'h20000, 32'h0, 32'h0, 1'b0);
        add_atom(32'h10000, 32'h10000, 32'h0, 1'b1);
        // exactly at the radius: no merge
        add_atom(32'h0, 32'h0, 32'h0, 1'b0);
        add_atom(32'h30000, 32'h0, 32'h0, 1'b1);
        // difference beyond 32 bits without a box
        add_atom(32'h7FFFFFFF, 32'h0, 32'h0, 1'b0);
        add_atom(32'h80000000, 32'h0, 32'h0, 1'b1);
        add_reg(CFG_BOX_X, REG_MAX);
        add_reg(CFG_BOX_Y, 31'h100000);
        add_reg(CFG_RADIUS, REG_MAX);
        // wrapped midpoint saturates high, then low, then stays in range on y
        add_atom(32'h1FFFFFFF, 32'h0, 32'h0, 1'b0);
        add_atom(32'h7FFFFFFF, 32'h0, 32'h0, 1'b1);
        add_atom(32'hE0000000, 32'h0, 32'h0, 1'b0);
        add_atom(32'h80000000, 32'h0, 32'h0, 1'b1);
        add_atom(32'h0, 32'h10000, 32'h0, 1'b0);
        add_atom(32'h0, 32'hF0000, 32'h0, 1'b1);
        add_reg(CFG_RADIUS, '0);
        add_typed(32'h50000, 32'h50000, 32'h50000, 32'h50000, 32'h50000, 32'h50000);
        add_atom(32'h50000, 32'h50000, 32'h50000, 1'b0);
        add_atom(32'h50000, 32'h50000, 32'h50000, 1'b1);
        add_reg(CFG_BOX_X, 31'h40000);
        add_reg(CFG_BOX_Y, 31'h40000);
        add_reg(CFG_BOX_Z, 31'h40000);
        add_reg(CFG_RADIUS, 31'h10000);
        add_atom(32'h1C000, 32'h0, 32'h0, 1'b0);
        add_atom(32'hFFFE4000, 32'h0, 32'h0, 1'b0);
        add_atom(32'h8000, 32'h20000, 32'hFFFE0000, 1'b1);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            r = stim_rows[k];
            if (r.kind == ROW_REG) begin
                wait_idle();
                write_reg(r.reg_idx, r.reg_val);
            end else begin
                send_atom(r.x, r.y, r.z, r.closes, 1'b1);
                if (r.typed) begin
                    void'(expected_atoms.pop_back());
                    typed.idx     = '0;
                    typed.x       = r.ex;
                    typed.y       = r.ey;
                    typed.z       = r.ez;
                    typed.removed = 1'b0;
                    typed.ovf     = 1'b0;
                    typed.eos     = 1'b1;
                    expected_atoms.push_back(typed);
                end
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            wait_idle();
            write_reg(CFG_BOX_X, pick_reg(1'b0));
            write_reg(CFG_BOX_Y, pick_reg(1'b0));
            write_reg(CFG_BOX_Z, pick_reg(1'b0));
            write_reg(CFG_RADIUS, pick_reg(1'b1));
            n_sets = $urandom_range(2, 4);
            for (int s = 0; s < n_sets; s++) begin
                if ($urandom_range(4) == 0) wait_idle();
                if (phase == 1 && s == 0) begin
                    // fills the store, then one dropped atom and a dropped closing atom
                    send_set(MAX_ATOMS + 2, 1'b0);
                    sent += MAX_ATOMS + 2;
                end else begin
                    set_size = int'($urandom_range(1, 6));
                    send_set(set_size, 1'b1);
                    sent += set_size;
                end
            end
            phase++;
        end

        hold_start_low();
        waited = 0;
        while (expected_atoms.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (n_mismatch == 0 && expected_atoms.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/pcpm_pkg.sv
hdl/pcpm_cfg_regs.sv
hdl/pcpm_pair_unit.sv
hdl/periodic_close_point_merger_top.sv
tb/tb_top.sv
